// ===== rtl/core/rsp_pkg.sv =====
package rsp_pkg;

    // Capacity of the parity and generator stores
    localparam int MAX_CHECK_SYMBOLS = 64;

    // Check-symbol count after reset
    localparam logic [5:0] CHECK_COUNT_RESET = 6'd5;

    // Field polynomial x^8+x^5+x^3+x^2+1
    localparam logic [8:0] GF_POLY = 9'h12D;

    // Primitive element, first generator root
    localparam logic [7:0] GF_ALPHA = 8'h02;

    // One queued input beat
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } rsp_item_t;

    // Multiply by alpha with reduction
    function automatic logic [7:0] gf_xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? GF_POLY[7:0] : 8'h00);
    endfunction

    // Full GF(256) multiply, shift-and-add
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] x;
        logic [7:0] p;
        x = a;
        p = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
            begin
                p = p ^ x;
            end
            x = gf_xtime(x);
        end
        return p;
    endfunction

endpackage

// ===== rtl/core/reed_solomon_parity_encoder_unit.sv =====
// Systematic Reed-Solomon encoder over GF(256), field polynomial 0x12D, generator
// roots alpha^1..alpha^n. Each input beat is echoed on the output (tuser low) one
// beat per cycle unless the output stalls or a build runs; the beat with tlast set
// is followed by n check bytes, highest degree first, tuser high, tlast on the last
// one. A block of k data bytes thus occupies k + n output beats, all passing through
// the single output register. Writing check_count (0 means 1, above MAX_CHECK_SYMBOLS
// saturates) clears the remainder and rebuilds the generator one root per cycle,
// during which neither input nor configuration beats are taken; the same build runs after reset.
module reed_solomon_parity_encoder_unit #(
    parameter int MAX_CHECK_SYMBOLS = rsp_pkg::MAX_CHECK_SYMBOLS
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [5:0] cfg_data,   // check_count
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] data_byte
    input  logic       s_tlast,    // block_end
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] codeword
    output logic       m_tuser,    // is_check
    output logic       m_tlast     // final_flag
);

    localparam int N_W = $clog2(MAX_CHECK_SYMBOLS + 1);

    logic               busy;
    logic [N_W-1:0]     n_eff;
    logic [7:0]         gen [MAX_CHECK_SYMBOLS];
    logic               q_valid;
    logic               q_ready;
    rsp_pkg::rsp_item_t q_item;
    logic               cfg_acc;

    assign cfg_acc = cfg_valid && cfg_ready;

    rsp_gen #(
        .MAX_CHECK_SYMBOLS (MAX_CHECK_SYMBOLS)
    ) u_gen (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .busy      (busy),
        .n_eff     (n_eff),
        .gen       (gen)
    );

    rsp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .hold     (busy),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    rsp_back #(
        .MAX_CHECK_SYMBOLS (MAX_CHECK_SYMBOLS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (cfg_acc),
        .busy     (busy),
        .n_eff    (n_eff),
        .gen      (gen),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== rtl/core/rsp_gen.sv =====
// Generator polynomial builder: one root multiplied in per cycle
module rsp_gen #(
    parameter int MAX_CHECK_SYMBOLS = rsp_pkg::MAX_CHECK_SYMBOLS,
    localparam int N_W = $clog2(MAX_CHECK_SYMBOLS + 1),
    localparam int IDX_W = $clog2(MAX_CHECK_SYMBOLS)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [5:0]       cfg_data,
    output logic             busy,
    output logic [N_W-1:0]   n_eff,
    output logic [7:0]       gen [MAX_CHECK_SYMBOLS]
);

    localparam int CW = 6;
    localparam int EW = (N_W > CW) ? N_W : CW;

    logic [5:0]       count_reg;
    logic             busy_reg;
    logic [IDX_W-1:0] step_reg;
    logic [7:0]       root_reg;
    logic [7:0]       coef_reg  [MAX_CHECK_SYMBOLS + 1];
    logic [7:0]       coef_next [MAX_CHECK_SYMBOLS + 1];
    logic [EW-1:0]    count_ext;
    logic [N_W-1:0]   n_m1;
    logic             cfg_acc;

    assign cfg_ready = !busy_reg;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign busy      = busy_reg;

    // Effective count: zero acts as one, saturate at capacity
    assign count_ext = EW'(count_reg);
    always_comb
    begin
        if (count_reg == 6'd0)
        begin
            n_eff = N_W'(1);
        end
        else if (count_ext > EW'(MAX_CHECK_SYMBOLS))
        begin
            n_eff = N_W'(MAX_CHECK_SYMBOLS);
        end
        else
        begin
            n_eff = N_W'(count_ext);
        end
    end

    assign n_m1 = n_eff - N_W'(1);

    // Multiply current polynomial by (x + root)
    always_comb
    begin
        for (int j = 0; j <= MAX_CHECK_SYMBOLS; j++)
        begin
            if (j == 0)
            begin
                coef_next[j] = rsp_pkg::gf_mul(coef_reg[j], root_reg);
            end
            else
            begin
                coef_next[j] = coef_reg[j-1] ^ rsp_pkg::gf_mul(coef_reg[j], root_reg);
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < MAX_CHECK_SYMBOLS; k++)
        begin
            gen[k] = coef_reg[k];
        end
    end

    // Build sequencer; reset starts a build for the reset count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= rsp_pkg::CHECK_COUNT_RESET;
            busy_reg  <= 1'b1;
            step_reg  <= '0;
            root_reg  <= rsp_pkg::GF_ALPHA;
            for (int j = 0; j <= MAX_CHECK_SYMBOLS; j++)
            begin
                coef_reg[j] <= (j == 0) ? 8'h01 : 8'h00;
            end
        end
        else if (cfg_acc)
        begin
            count_reg <= cfg_data;
            busy_reg  <= 1'b1;
            step_reg  <= '0;
            root_reg  <= rsp_pkg::GF_ALPHA;
            for (int j = 0; j <= MAX_CHECK_SYMBOLS; j++)
            begin
                coef_reg[j] <= (j == 0) ? 8'h01 : 8'h00;
            end
        end
        else if (busy_reg)
        begin
            coef_reg <= coef_next;
            root_reg <= rsp_pkg::gf_xtime(root_reg);
            if (step_reg == n_m1[IDX_W-1:0])
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                step_reg <= step_reg + IDX_W'(1);
            end
        end
    end

endmodule

// ===== rtl/core/rsp_front.sv =====
// Input side: two-entry queue of incoming beats
module rsp_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              hold,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,
    input  logic              s_tlast,
    output logic              q_valid,
    input  logic              q_ready,
    output rsp_pkg::rsp_item_t q_item
);

    rsp_pkg::rsp_item_t slot_reg [2];
    logic               wr_ptr_reg;
    logic               rd_ptr_reg;
    logic [1:0]         fill_reg;
    logic               push;
    logic               pop;

    assign s_tready = (fill_reg != 2'd2) && !hold;
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (fill_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_item   = slot_reg[rd_ptr_reg];

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= '{data: s_tdata, last: s_tlast};
        end
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   fill_reg <= fill_reg + 2'd1;
                2'b01:   fill_reg <= fill_reg - 2'd1;
                default: fill_reg <= fill_reg;
            endcase
        end
    end

endmodule

// ===== rtl/core/rsp_back.sv =====
// Output side: LFSR division, check emission and output register
module rsp_back #(
    parameter int MAX_CHECK_SYMBOLS = rsp_pkg::MAX_CHECK_SYMBOLS,
    localparam int N_W = $clog2(MAX_CHECK_SYMBOLS + 1),
    localparam int IDX_W = $clog2(MAX_CHECK_SYMBOLS)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               clear,
    input  logic               busy,
    input  logic [N_W-1:0]     n_eff,
    input  logic [7:0]         gen [MAX_CHECK_SYMBOLS],
    input  logic               q_valid,
    output logic               q_ready,
    input  rsp_pkg::rsp_item_t q_item,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata,
    output logic               m_tuser,
    output logic               m_tlast
);

    typedef enum logic [1:0] {
        ST_DATA  = 2'b01,
        ST_CHECK = 2'b10
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [7:0]       parity_reg  [MAX_CHECK_SYMBOLS];
    logic [7:0]       parity_next [MAX_CHECK_SYMBOLS];
    logic [IDX_W-1:0] cnt_reg;
    logic [IDX_W-1:0] cnt_next;
    logic             valid_reg;
    logic             valid_next;
    logic [7:0]       data_reg;
    logic [7:0]       data_next;
    logic             user_reg;
    logic             user_next;
    logic             last_reg;
    logic             last_next;
    logic [N_W-1:0]   n_m1_full;
    logic [IDX_W-1:0] n_m1;
    logic             out_free;
    logic             pop;
    logic [7:0]       fb;
    logic             final_chk;

    assign n_m1_full = n_eff - N_W'(1);
    assign n_m1      = n_m1_full[IDX_W-1:0];
    assign out_free  = !valid_reg || m_tready;
    assign pop       = (state_reg == ST_DATA) && q_valid && out_free && !busy;
    assign q_ready   = pop;
    assign fb        = parity_reg[n_m1] ^ q_item.data;
    assign final_chk = (cnt_reg == n_m1);

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

    // Next state of sequencer, parity and output register
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        parity_next = parity_reg;
        valid_next  = valid_reg;
        data_next   = data_reg;
        user_next   = user_reg;
        last_next   = last_reg;
        if (out_free)
        begin
            valid_next = 1'b0;
        end
        case (state_reg)
            ST_DATA:
            begin
                if (pop)
                begin
                    // Echo the byte and divide it into the remainder
                    valid_next = 1'b1;
                    data_next  = q_item.data;
                    user_next  = 1'b0;
                    last_next  = 1'b0;
                    for (int k = 0; k < MAX_CHECK_SYMBOLS; k++)
                    begin
                        if (N_W'(k) >= n_eff)
                        begin
                            parity_next[k] = 8'h00;
                        end
                        else if (k == 0)
                        begin
                            parity_next[k] = rsp_pkg::gf_mul(fb, gen[k]);
                        end
                        else
                        begin
                            parity_next[k] = parity_reg[k-1] ^ rsp_pkg::gf_mul(fb, gen[k]);
                        end
                    end
                    if (q_item.last)
                    begin
                        state_next = ST_CHECK;
                        cnt_next   = '0;
                    end
                end
            end
            ST_CHECK:
            begin
                if (out_free)
                begin
                    // Highest degree first, shifting zeros in behind
                    valid_next = 1'b1;
                    data_next  = parity_reg[n_m1];
                    user_next  = 1'b1;
                    last_next  = final_chk;
                    for (int k = 0; k < MAX_CHECK_SYMBOLS; k++)
                    begin
                        if (k == 0 || N_W'(k) >= n_eff)
                        begin
                            parity_next[k] = 8'h00;
                        end
                        else
                        begin
                            parity_next[k] = parity_reg[k-1];
                        end
                    end
                    cnt_next = cnt_reg + IDX_W'(1);
                    if (final_chk)
                    begin
                        state_next = ST_DATA;
                    end
                end
            end
            default:
            begin
                state_next = ST_DATA;
            end
        endcase
        if (clear)
        begin
            for (int k = 0; k < MAX_CHECK_SYMBOLS; k++)
            begin
                parity_next[k] = 8'h00;
            end
        end
    end

    // Control and remainder registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_DATA;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
            for (int k = 0; k < MAX_CHECK_SYMBOLS; k++)
            begin
                parity_reg[k] <= 8'h00;
            end
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            valid_reg  <= valid_next;
            parity_reg <= parity_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        user_reg <= user_next;
        last_reg <= last_next;
    end

endmodule

// ===== rtl/core/rsp_chk.sv =====
// Port-level checks for the encoder
module rsp_chk (
    input logic       clk,
    input logic       rst_n,
    input logic       cfg_valid,
    input logic       cfg_ready,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tuser,
    input logic       m_tlast
);

    // A stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("output beat changed under stall");

    // Only a check byte may close a block
    a_last_is_check: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser)
        else $error("tlast on a data echo");

    // A count write starts a rebuild that holds off input
    a_cfg_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> !s_tready && !cfg_ready)
        else $error("input taken during generator rebuild");

    // When a rebuild ends and configuration reopens, input was still held off just before
    a_cfg_vs_in: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready && !$past(cfg_ready) |-> !$past(s_tready))
        else $error("input was open while generator was being built");

endmodule

bind reed_solomon_parity_encoder_unit rsp_chk u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
);

// ===== tb/sv/tb_reed_solomon_parity_encoder_unit.sv =====
`timescale 1ns / 1ps

module tb_reed_solomon_parity_encoder_unit;

    localparam int NSYM          = rsp_pkg::MAX_CHECK_SYMBOLS;
    localparam int ITEM_TARGET   = 270;
    localparam int STALL_LIMIT   = 4000;
    localparam int LONG_HOLD     = 200;
    localparam int SETTLE_CYCLES = 8;

    // One output beat as the encoder should present it
    typedef struct packed {
        logic [7:0] codeword;
        logic       is_check;
        logic       final_flag;
    } rs_word_t;

    // Encoder predictor plus queue of codewords still owed by the block
    class rs_encoder_scoreboard;
        logic [7:0] alog [255];
        int         logt [256];
        logic [7:0] gen_low [NSYM];
        logic [7:0] remainder [NSYM];
        int         num_checks;
        rs_word_t   pending_codewords [$];
        int         errors;
        int         data_seen;
        int         checks_seen;
        int         blocks_done;

        function new();
            logic [8:0] t;
            logic [7:0] x;
            // log / antilog tables, independent of the shift-and-add multiply
            x = 8'h01;
            logt[0] = 0;
            for (int i = 0; i < 255; i++)
            begin
                alog[i] = x;
                logt[x] = i;
                t = {x, 1'b0};
                if (t[8])
                begin
                    t = t ^ rsp_pkg::GF_POLY;
                end
                x = t[7:0];
            end
            errors      = 0;
            data_seen   = 0;
            checks_seen = 0;
            blocks_done = 0;
            set_check_count(rsp_pkg::CHECK_COUNT_RESET);
        endfunction

        function logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
            if (a == 8'h00 || b == 8'h00)
            begin
                return 8'h00;
            end
            return alog[(logt[a] + logt[b]) % 255];
        endfunction

        // Product of (x + alpha^i), i = 1..n; leading 1 dropped
        function void rebuild_generator();
            logic [7:0] poly [NSYM + 1];
            logic [7:0] root;
            foreach (poly[j])
            begin
                poly[j] = 8'h00;
            end
            poly[0] = 8'h01;
            root    = 8'h01;
            for (int i = 0; i < num_checks; i++)
            begin
                root = gf_times(root, rsp_pkg::GF_ALPHA);
                for (int j = i + 1; j >= 1; j--)
                begin
                    poly[j] = poly[j - 1] ^ gf_times(poly[j], root);
                end
                poly[0] = gf_times(poly[0], root);
            end
            for (int k = 0; k < NSYM; k++)
            begin
                gen_low[k] = (k < num_checks) ? poly[k] : 8'h00;
            end
        endfunction

        // Zero means one check byte; anything past capacity saturates
        function void set_check_count(input logic [5:0] v);
            num_checks = (v == 6'd0) ? 1 : int'(v);
            if (num_checks > NSYM)
            begin
                num_checks = NSYM;
            end
            rebuild_generator();
            foreach (remainder[k])
            begin
                remainder[k] = 8'h00;
            end
        endfunction

        // Shift one data byte through the division register
        function void absorb_data_byte(input logic [7:0] d, input logic blk_end);
            logic [7:0] fb;
            fb = remainder[num_checks - 1] ^ d;
            for (int k = num_checks - 1; k > 0; k--)
            begin
                remainder[k] = remainder[k - 1] ^ gf_times(fb, gen_low[k]);
            end
            remainder[0] = gf_times(fb, gen_low[0]);
            pending_codewords.push_back('{codeword: d, is_check: 1'b0, final_flag: 1'b0});
            data_seen++;
            if (blk_end)
            begin
                // check bytes go out highest degree first
                for (int k = 0; k < num_checks; k++)
                begin
                    pending_codewords.push_back('{codeword: remainder[num_checks - 1 - k],
                                                  is_check: 1'b1,
                                                  final_flag: (k == num_checks - 1)});
                end
                foreach (remainder[k])
                begin
                    remainder[k] = 8'h00;
                end
                blocks_done++;
            end
        endfunction

        function void check_codeword(input rs_word_t got);
            rs_word_t want;
            if (pending_codewords.size() == 0)
            begin
                $error("codeword %h (is_check %b, final_flag %b) with nothing expected",
                       got.codeword, got.is_check, got.final_flag);
                errors++;
                return;
            end
            want = pending_codewords.pop_front();
            if (got.codeword !== want.codeword)
            begin
                $error("codeword: expected %h, actual %h", want.codeword, got.codeword);
                errors++;
            end
            if (got.is_check !== want.is_check)
            begin
                $error("is_check: expected %b, actual %b", want.is_check, got.is_check);
                errors++;
            end
            if (got.final_flag !== want.final_flag)
            begin
                $error("final_flag: expected %b, actual %b", want.final_flag, got.final_flag);
                errors++;
            end
            if (want.is_check)
            begin
                checks_seen++;
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [5:0] cfg_data;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tuser;
    logic       m_tlast;

    rs_encoder_scoreboard rs_sb;

    bit sender_gaps_on   = 1'b0;
    bit receiver_gaps_on = 1'b0;
    bit hold_off_request = 1'b0;
    int items_sent       = 0;
    int count_writes     = 0;
    int quiet_cycles     = 0;

    reed_solomon_parity_encoder_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Watchdog: too long without any beat on any channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no beat for %0d cycles", STALL_LIMIT);
                $display("status: fail");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Output side: random stalls, one long hold-off on request
    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = receiver_gaps_on ? $urandom_range(0, 7) : 0;
            if (hold_off_request)
            begin
                stall            = LONG_HOLD;
                hold_off_request = 1'b0;
            end
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
            begin
                @(posedge clk);
            end
            rs_sb.check_codeword('{codeword: m_tdata, is_check: m_tuser, final_flag: m_tlast});
            @(negedge clk);
        end
    end

    // Offer one data beat; entered and left at a falling edge
    task automatic send_byte(input logic [7:0] d, input logic blk_end);
        int gap;
        gap = sender_gaps_on ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tlast  <= blk_end;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        rs_sb.absorb_data_byte(d, blk_end);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_block(input int len, input bit closed);
        for (int i = 0; i < len; i++)
        begin
            send_byte(8'($urandom_range(0, 255)), closed && (i == len - 1));
        end
    endtask

    // Stop offering, wait for every owed codeword, then let the block settle
    task automatic drain_encoder();
        s_tvalid <= 1'b0;
        while (rs_sb.pending_codewords.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_check_count(input logic [5:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        rs_sb.set_check_count(v);
        count_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int         phase;
        int         n_blocks;
        int         pick;
        logic [5:0] cc;

        rs_sb     = new();
        cfg_valid = 1'b0;
        cfg_data  = 6'd0;
        s_tvalid  = 1'b0;
        s_tdata   = 8'h00;
        s_tlast   = 1'b0;
        rst_n     = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: reset count, first with no gaps, then with gaps on both sides
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b1);
        sender_gaps_on   = 1'b1;
        receiver_gaps_on = 1'b1;
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h00, 1'b1);
        drain_encoder();

        // zero count behaves as one check byte
        write_check_count(6'd0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b1);
        drain_encoder();

        // widest count the register can hold
        write_check_count(6'd63);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        drain_encoder();

        // count rewritten mid-block restarts the remainder
        write_check_count(6'd1);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b0);
        drain_encoder();
        write_check_count(6'd2);
        send_byte(8'hC3, 1'b1);
        drain_encoder();

        // Random phases; the first one backs up against a long output hold-off
        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                cc = 6'd63;
            end
            else if (pick == 1)
            begin
                cc = 6'd0;
            end
            else if (pick == 2)
            begin
                cc = 6'd1;
            end
            else
            begin
                cc = 6'($urandom_range(2, 16));
            end
            if (phase == 0 || $urandom_range(0, 3) != 0)
            begin
                write_check_count(cc);
            end
            if (phase == 0)
            begin
                sender_gaps_on   = 1'b0;
                receiver_gaps_on = 1'b1;
                hold_off_request = 1'b1;
                n_blocks         = 4;
            end
            else
            begin
                sender_gaps_on   = ($urandom_range(0, 3) != 0);
                receiver_gaps_on = ($urandom_range(0, 3) != 0);
                n_blocks         = $urandom_range(1, 4);
            end
            for (int b = 0; b < n_blocks; b++)
            begin
                send_block((phase == 0) ? 12 : $urandom_range(1, 12), 1'b1);
            end
            // now and then leave a block open across the count write
            if ($urandom_range(0, 7) == 0)
            begin
                send_block($urandom_range(1, 5), 1'b0);
            end
            drain_encoder();
            phase++;
        end

        sender_gaps_on = 1'b0;
        drain_encoder();
        if (rs_sb.pending_codewords.size() != 0)
        begin
            $error("%0d codewords never arrived", rs_sb.pending_codewords.size());
            rs_sb.errors += rs_sb.pending_codewords.size();
        end

        $display("summary: %0d data bytes, %0d closed blocks, %0d check bytes, %0d count writes",
                 rs_sb.data_seen, rs_sb.blocks_done, rs_sb.checks_seen, count_writes);
        $display("summary: random gaps on both sides plus a %0d-cycle output hold-off",
                 LONG_HOLD);
        if (rs_sb.errors == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/rsp_pkg.sv
rtl/core/rsp_gen.sv
rtl/core/rsp_front.sv
rtl/core/rsp_back.sv
rtl/core/reed_solomon_parity_encoder_unit.sv
rtl/core/rsp_chk.sv
tb/sv/tb_reed_solomon_parity_encoder_unit.sv
